@@ sv/srarq_pkg.sv @@
// ----------------------------------------------------------------------------
// srarq_pkg
// shared widths, result codes and word types of the selective-repeat receiver
// ----------------------------------------------------------------------------
`default_nettype none

package srarq_pkg;

  // window and payload geometry
  localparam int WINDOW        = 8;
  localparam int PAYLOAD_BYTES = 8;
  localparam int IDX_W         = $clog2(WINDOW);

  // field widths of the frame and result words
  localparam int SEQ_W  = 3;
  localparam int DATA_W = 64;
  localparam int LEN_W  = 4;
  localparam int CHK_W  = 8;
  localparam int KIND_W = 2;
  localparam int SLOT_W = DATA_W + LEN_W;

  // ascii '0' is the base of the check character
  localparam logic [CHK_W-1:0] CHECK_BASE = CHK_W'(48);
  localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(PAYLOAD_BYTES);

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DELIVER = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_ACK     = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_NAK     = KIND_W'(2);

  typedef struct packed {
    logic [SEQ_W-1:0]  seq_num;
    logic [DATA_W-1:0] payload;
    logic [LEN_W-1:0]  payload_len;
    logic [CHK_W-1:0]  check_char;
  } frame_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  number;
    logic [DATA_W-1:0] data_out;
    logic [LEN_W-1:0]  data_len;
    logic              last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit_nak;
    logic store;
    logic deliver;
    logic ack;
    logic last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic nak_emit;
    logic store_ok;
    logic will_deliver;
    logic full_next;
  } dp_status_t;

endpackage

`default_nettype wire

@@ sv/selective_repeat_arq_receiver.sv @@
// ----------------------------------------------------------------------------
// selective_repeat_arq_receiver
// receiver side of selective-repeat arq with an eight-slot reorder window
// ----------------------------------------------------------------------------
// A frame word is taken on a rising edge with start high and busy low. Each
// result word sits on result for exactly one cycle, marked by strobe; the
// receiver of results cannot stall the block, so it must take every word on
// the cycle it appears. A frame that delivers nothing (corrupt, out of order,
// duplicate) keeps busy high through the evaluate state only, and its single
// nak, if any, shows in the cycle after evaluate. A frame that releases N stored
// slots keeps busy high through these steps: evaluate and write the slot ram,
// the registered ram read of the expected slot, one step per delivered slot,
// and the closing ack. The slot ram's read, one slot per cycle, sets the pace
// of a delivery run. The block comes out of reset ready, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_arq_receiver
  import srarq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire frame_t frame,
  output logic        busy,
  output logic        strobe,
  output result_t     result
);

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: idle, evaluate, ram lead cycle, delivery run, ack
  srarq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // datapath: window state, slot ram and the registered result word
  srarq_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame),
    .cmd    (cmd),
    .status (status),
    .strobe (strobe),
    .result (result)
  );

endmodule

`default_nettype wire

@@ sv/srarq_ram.sv @@
// ----------------------------------------------------------------------------
// srarq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module srarq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/srarq_ctrl.sv @@
// ----------------------------------------------------------------------------
// srarq_ctrl
// sequencer of the receiver: evaluate, ram lead, delivery run, closing ack
// ----------------------------------------------------------------------------
`default_nettype none

module srarq_ctrl
  import srarq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t status,
  output logic            busy,
  output dp_cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_DELIV = 3'd3;
  localparam logic [2:0] ST_ACK   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.emit_nak = status.nak_emit;
        cmd.last     = !status.will_deliver;
        cmd.store    = status.store_ok;
        state_next   = status.will_deliver ? ST_PREP : ST_IDLE;
      end
      // slot ram read of the expected slot is in flight
      ST_PREP: begin
        state_next = ST_DELIV;
      end
      ST_DELIV: begin
        cmd.deliver = 1'b1;
        state_next  = status.full_next ? ST_DELIV : ST_ACK;
      end
      ST_ACK: begin
        cmd.ack    = 1'b1;
        cmd.last   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

@@ sv/srarq_dp.sv @@
// ----------------------------------------------------------------------------
// srarq_dp
// receiver datapath: frame register, window state, slot ram, result register
// ----------------------------------------------------------------------------
`default_nettype none

module srarq_dp
  import srarq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire frame_t  frame,
  input  wire dp_cmd_t cmd,
  output dp_status_t   status,
  output logic         strobe,
  output result_t      result
);

  frame_t              frame_q;
  logic [IDX_W-1:0]    expected;
  logic [IDX_W-1:0]    expected_inc;
  logic                nak_out;
  logic [WINDOW-1:0]   slot_full;
  logic                res_valid;
  result_t             res_q;
  result_t             res_next;

  logic [IDX_W-1:0]    seq_idx;
  logic                seq_in_win;
  logic                seq_is_exp;
  logic                corrupt;
  logic [LEN_W-1:0]    len_clip;
  logic [DATA_W-1:0]   data_mask;
  logic [SLOT_W-1:0]   wdata;
  logic [SLOT_W-1:0]   rdata;
  logic [IDX_W-1:0]    raddr;

  // frame register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_q <= frame;
    end
  end

  assign seq_idx      = IDX_W'(frame_q.seq_num);
  assign seq_in_win   = (32'(frame_q.seq_num) < WINDOW);
  assign seq_is_exp   = (32'(frame_q.seq_num) == 32'(expected));
  assign corrupt      = frame_q.check_char != (CHECK_BASE + CHK_W'(frame_q.payload_len));
  assign expected_inc = (expected == IDX_W'(WINDOW - 1)) ? '0 : expected + 1'b1;

  assign status.nak_emit     = !nak_out && (corrupt || !seq_is_exp);
  assign status.store_ok     = !corrupt && seq_in_win && !slot_full[seq_idx];
  assign status.will_deliver = status.store_ok && (seq_is_exp || slot_full[expected]);
  assign status.full_next    = slot_full[expected_inc];

  // long payloads are cut, bytes past the length are zeroed
  assign len_clip = (frame_q.payload_len > LEN_MAX) ? LEN_MAX : frame_q.payload_len;

  always_comb begin
    data_mask = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      data_mask[i*8 +: 8] = (LEN_W'(i) < len_clip) ? 8'hff : 8'h00;
    end
  end

  assign wdata = {len_clip, frame_q.payload & data_mask};

  // during a delivery run the ram already reads the following slot
  assign raddr = cmd.deliver ? expected_inc : expected;

  srarq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (WINDOW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (seq_idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      expected  <= '0;
      nak_out   <= 1'b0;
      slot_full <= '0;
    end else begin
      if (cmd.emit_nak) begin
        nak_out <= 1'b1;
      end
      if (cmd.ack) begin
        nak_out <= 1'b0;
      end
      if (cmd.store) begin
        slot_full[seq_idx] <= 1'b1;
      end
      if (cmd.deliver) begin
        slot_full[expected] <= 1'b0;
        expected            <= expected_inc;
      end
    end
  end

  // result word
  always_comb begin
    res_next        = '0;
    res_next.number = SEQ_W'(expected);
    res_next.last   = cmd.last;
    if (cmd.emit_nak) begin
      res_next.kind = KIND_NAK;
    end else if (cmd.ack) begin
      res_next.kind = KIND_ACK;
    end else begin
      res_next.kind     = KIND_DELIVER;
      res_next.data_out = rdata[DATA_W-1:0];
      res_next.data_len = rdata[SLOT_W-1:DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.emit_nak || cmd.ack || cmd.deliver;
    end
  end

  always_ff @(posedge clk) begin
    res_q <= res_next;
  end

  assign strobe = res_valid;
  assign result = res_q;

`ifndef SYNTHESIS
  a_idle_exp_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !slot_full[expected])
    else $error("expected slot full between frames");

  a_store_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (seq_in_win && !slot_full[seq_idx]))
    else $error("store into a full or out-of-window slot");

  a_deliver_full: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> slot_full[expected])
    else $error("delivery from an empty slot");

  a_ack_clears_nak: assert property (@(posedge clk) disable iff (rst)
    cmd.ack |=> (!nak_out && strobe && result.kind == KIND_ACK && result.last))
    else $error("ack did not close the frame or clear the nak");
`endif

endmodule

`default_nettype wire
